// ----- src/a16fd_pkg.sv -----
package a16fd_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STAGES = WORD_W / DIV_STEPS;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_CMP = 3'd4,
        ACT_SLT = 3'd5,
        ACT_SGT = 3'd6,
        ACT_ADC = 3'd7
    } t_action;

    typedef struct packed {
        logic eq;
        logic gtu;
        logic ltu;
        logic gts;
        logic lts;
    } t_rel;

    typedef struct packed {
        t_action             action;
        logic                dest_alias;
        logic [WORD_W-1:0]   a;
        logic [WORD_W-1:0]   b;
        logic [WORD_W:0]     sum;
        logic [2*WORD_W-1:0] product;
        t_rel                rel;
        logic [WORD_W-1:0]   dvsr;
        logic [WORD_W-1:0]   rem;
        logic [WORD_W-1:0]   quo;
    } t_item;

endpackage

// ----- src/alu16_flags_floor_div_top.sv -----
// 16-bit two's complement alu with condition flags and floored divide
// input channel: i_valid / o_stall with i_action, i_operand_a, i_operand_b,
//   i_carry_in and i_dest_alias; an item is taken when i_valid and not o_stall
// output channel: o_valid / i_stall with the result fields and written bits;
//   a result is taken when o_valid and not i_stall
// every item gives exactly one result, all actions share one pipeline
// the pipeline is seven registers deep (prepare, multiply and first divide
//   digits, three more divide stages of four quotient bits each, sign restore,
//   result select into the output register)
// throughput: one item per cycle while the output is not stalled
// a stall at the output (i_stall while o_valid) freezes the whole pipeline and raises o_stall;
//   nothing is lost or repeated, the output holds steady while stalled
// reset (i_rst_n low, synchronous) empties the pipeline, clears all valid bits
module alu16_flags_floor_div_top
    import a16fd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_action,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    input  logic              i_carry_in,
    input  logic              i_dest_alias,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_primary_result,
    output logic [WORD_W-1:0] o_remainder_result,
    output logic              o_primary_written,
    output logic              o_remainder_written,
    output logic              o_flags_written,
    output logic              o_carry_flag,
    output logic              o_signed_overflow,
    output logic              o_equal_flag,
    output logic              o_greater_unsigned,
    output logic              o_less_unsigned,
    output logic              o_greater_signed,
    output logic              o_less_signed
);

    localparam int unsigned NST = DIV_STAGES + 2;

    logic  en;
    t_item r_st [NST];
    logic  r_v  [NST];
    t_item n_st [NST];
    logic  [WORD_W-1:0] div_rem [DIV_STAGES];
    logic  [WORD_W-1:0] div_quo [DIV_STAGES];

    logic [WORD_W-1:0] r_primary, n_primary;
    logic [WORD_W-1:0] r_remainder, n_remainder;
    logic r_pw, n_pw, r_rw, n_rw, r_fw, n_fw, r_cf, n_cf, r_sovf, n_sovf;
    t_rel r_rel, n_rel;
    logic r_ov;

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;

    // prepare
    always_comb begin
        logic [WORD_W-1:0] opb;
        logic              cin;
        opb = i_operand_b;
        cin = 1'b0;
        if (t_action'(i_action) == ACT_SUB) begin
            opb = WORD_W'(~i_operand_b + 1'b1);
        end
        if (t_action'(i_action) == ACT_ADC) begin
            cin = i_carry_in;
        end
        n_st[0]            = '0;
        n_st[0].action     = t_action'(i_action);
        n_st[0].dest_alias = i_dest_alias;
        n_st[0].a          = i_operand_a;
        n_st[0].b          = opb;
        n_st[0].sum        = {1'b0, i_operand_a} + {1'b0, opb} + {{WORD_W{1'b0}}, cin};
        n_st[0].rel.eq     = i_operand_a == i_operand_b;
        n_st[0].rel.gtu    = i_operand_a > i_operand_b;
        n_st[0].rel.ltu    = i_operand_a < i_operand_b;
        n_st[0].rel.gts    = $signed(i_operand_a) > $signed(i_operand_b);
        n_st[0].rel.lts    = $signed(i_operand_a) < $signed(i_operand_b);
        n_st[0].quo        = i_operand_a[WORD_W-1] ? WORD_W'(-i_operand_a) : i_operand_a;
        n_st[0].dvsr       = i_operand_b[WORD_W-1] ? WORD_W'(-i_operand_b) : i_operand_b;
        n_st[0].rem        = '0;
    end

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_div
            a16fd_div_stage #(.STEPS(DIV_STEPS)) u_div (
                .i_dvsr (r_st[g].dvsr),
                .i_rem  (r_st[g].rem),
                .i_quo  (r_st[g].quo),
                .o_rem  (div_rem[g]),
                .o_quo  (div_quo[g])
            );
            always_comb begin
                n_st[g+1]     = r_st[g];
                n_st[g+1].rem = div_rem[g];
                n_st[g+1].quo = div_quo[g];
                if (g == 0) begin
                    n_st[g+1].product = (2*WORD_W)'($signed(r_st[g].a) * $signed(r_st[g].b));
                end
            end
        end
    endgenerate

    // restore signs of truncated quotient and remainder
    always_comb begin
        n_st[NST-1] = r_st[NST-2];
        if (r_st[NST-2].a[WORD_W-1] ^ r_st[NST-2].b[WORD_W-1]) begin
            n_st[NST-1].quo = WORD_W'(-r_st[NST-2].quo);
        end
        if (r_st[NST-2].a[WORD_W-1]) begin
            n_st[NST-1].rem = WORD_W'(-r_st[NST-2].rem);
        end
    end

    // result select
    always_comb begin
        t_item it;
        logic  [WORD_W-1:0] q;
        logic  [WORD_W-1:0] r;
        it          = r_st[NST-1];
        q           = it.quo;
        r           = it.rem;
        n_primary   = '0;
        n_remainder = '0;
        n_pw        = 1'b0;
        n_rw        = 1'b0;
        n_fw        = 1'b0;
        n_cf        = 1'b0;
        n_sovf      = 1'b0;
        n_rel       = '0;
        case (it.action)
            ACT_ADD, ACT_SUB, ACT_ADC: begin
                n_primary = it.sum[WORD_W-1:0];
                n_pw      = 1'b1;
                if (!it.dest_alias) begin
                    n_fw   = 1'b1;
                    n_cf   = it.sum[WORD_W];
                    n_sovf = !(it.a[WORD_W-1] ^ it.b[WORD_W-1])
                             && (it.a[WORD_W-1] ^ it.sum[WORD_W-1]);
                end
            end
            ACT_MUL: begin
                n_primary = it.product[WORD_W-1:0];
                n_pw      = 1'b1;
                if (!it.dest_alias) begin
                    n_fw   = 1'b1;
                    n_sovf = !((&it.product[2*WORD_W-1:WORD_W-1])
                               || !(|it.product[2*WORD_W-1:WORD_W-1]));
                end
            end
            ACT_DIV: begin
                if (it.b != '0) begin
                    if (r != '0 && (it.a[WORD_W-1] ^ it.b[WORD_W-1])) begin
                        q = WORD_W'(q - 1'b1);
                        r = WORD_W'(r + it.b);
                    end
                    n_primary = q;
                    n_pw      = 1'b1;
                    if (!it.dest_alias) begin
                        n_remainder = r;
                        n_rw        = 1'b1;
                    end
                end
            end
            ACT_CMP: begin
                n_fw  = 1'b1;
                n_rel = it.rel;
            end
            ACT_SLT: begin
                n_primary = {{(WORD_W-1){1'b0}}, it.rel.lts};
                n_pw      = 1'b1;
            end
            ACT_SGT: begin
                n_primary = {{(WORD_W-1){1'b0}}, it.rel.gts};
                n_pw      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
            r_primary   <= n_primary;
            r_remainder <= n_remainder;
            r_pw        <= n_pw;
            r_rw        <= n_rw;
            r_fw        <= n_fw;
            r_cf        <= n_cf;
            r_sovf      <= n_sovf;
            r_rel       <= n_rel;
        end
    end

    assign o_valid             = r_ov;
    assign o_primary_result    = r_primary;
    assign o_remainder_result  = r_remainder;
    assign o_primary_written   = r_pw;
    assign o_remainder_written = r_rw;
    assign o_flags_written     = r_fw;
    assign o_carry_flag        = r_cf;
    assign o_signed_overflow   = r_sovf;
    assign o_equal_flag        = r_rel.eq;
    assign o_greater_unsigned  = r_rel.gtu;
    assign o_less_unsigned     = r_rel.ltu;
    assign o_greater_signed    = r_rel.gts;
    assign o_less_signed       = r_rel.lts;

endmodule

// ----- src/a16fd_div_stage.sv -----
module a16fd_div_stage
    import a16fd_pkg::*;
#(
    parameter int unsigned STEPS = DIV_STEPS
) (
    input  logic [WORD_W-1:0] i_dvsr,
    input  logic [WORD_W-1:0] i_rem,
    input  logic [WORD_W-1:0] i_quo,
    output logic [WORD_W-1:0] o_rem,
    output logic [WORD_W-1:0] o_quo
);

    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] quo;
    logic [WORD_W:0]   trial;

    // restoring steps, one quotient bit each
    always_comb begin
        rem   = i_rem;
        quo   = i_quo;
        trial = '0;
        for (int k = 0; k < STEPS; k++) begin
            trial = {rem, quo[WORD_W-1]};
            quo   = {quo[WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, i_dvsr}) begin
                trial  = trial - {1'b0, i_dvsr};
                quo[0] = 1'b1;
            end
            rem = trial[WORD_W-1:0];
        end
        o_rem = rem;
        o_quo = quo;
    end

endmodule
